// ===== sv/alpdf_pkg.sv =====
// Shared types and constants for the ASCII length-prefixed deframer.
`timescale 1ns / 1ps
`default_nettype none
package alpdf_pkg;

  localparam int BYTE_W = 8;
  localparam int CODE_W = 4;
  localparam int LEN_W = 14;
  localparam int POS_W = 3;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_PAYLOAD = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_HDR_ERR = 2'd2;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

  typedef struct packed {
    logic vld;
    logic [BYTE_W-1:0] data;
  } alpdf_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] payload_byte;
    logic [CODE_W-1:0] frame_code;
    logic [LEN_W-1:0] frame_length;
    logic last;
  } alpdf_res_t;

endpackage
`default_nettype wire

// ===== sv/alpdf_in_stage.sv =====
// Input register stage that holds one received byte for the decoder.
`timescale 1ns / 1ps
`default_nettype none
module alpdf_in_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [alpdf_pkg::BYTE_W-1:0] in_tdata,
  input  wire logic                      core_ready,
  output alpdf_pkg::alpdf_req_t          req
);
  import alpdf_pkg::*;

  logic              vld_r;
  logic              vld_nxt;
  logic [BYTE_W-1:0] data_r;

  assign in_tready = !vld_r || core_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (in_tready) begin
      vld_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      data_r <= in_tdata;
    end
  end

  assign req.vld = vld_r;
  assign req.data = data_r;

endmodule
`default_nettype wire

// ===== sv/alpdf_core.sv =====
// Header decoder, payload counter and result register of the deframer.
`timescale 1ns / 1ps
`default_nettype none
module alpdf_core #(
  parameter int LENGTH_DIGITS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  alpdf_pkg::alpdf_req_t     req,
  output logic                      core_ready,
  output logic                      res_vld,
  input  wire logic                 res_rdy,
  output alpdf_pkg::alpdf_res_t     res
);
  import alpdf_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(LENGTH_DIGITS);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             pay_r, pay_nxt;
  logic             bad_r, bad_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic             out_vld_r, out_vld_nxt;
  alpdf_res_t       out_r, out_nxt;
  logic             take;
  logic             emit;

  assign core_ready = !out_vld_r || res_rdy;
  assign take = req.vld && core_ready;

  always_comb begin
    logic              digit;
    logic [CODE_W-1:0] d;
    logic              done;
    logic              bad_new;
    logic [CODE_W-1:0] code_new;
    logic [LEN_W-1:0]  len_new;
    digit = (req.data >= ASCII_ZERO) && (req.data <= ASCII_NINE);
    d = digit ? CODE_W'(req.data - ASCII_ZERO) : '0;
    done = (cnt_r + LEN_W'(1)) == len_r;
    bad_new = bad_r || !digit;
    code_new = (pos_r == '0) ? d : code_r;
    len_new = (pos_r == '0) ? len_r
            : LEN_W'({len_r, 3'b000} + {len_r, 1'b0} + {{(LEN_W-CODE_W){1'b0}}, d});
    pos_nxt = pos_r;
    pay_nxt = pay_r;
    bad_nxt = bad_r;
    code_nxt = code_r;
    len_nxt = len_r;
    cnt_nxt = cnt_r;
    emit = 1'b0;
    out_nxt = '0;
    if (take) begin
      if (pay_r) begin
        emit = 1'b1;
        out_nxt.status = ST_PAYLOAD;
        out_nxt.payload_byte = req.data;
        out_nxt.frame_code = code_r;
        out_nxt.frame_length = len_r;
        out_nxt.last = done;
        cnt_nxt = cnt_r + LEN_W'(1);
        if (done) begin
          pos_nxt = '0;
          pay_nxt = 1'b0;
          bad_nxt = 1'b0;
          code_nxt = '0;
          len_nxt = '0;
          cnt_nxt = '0;
        end
      end else if (pos_r < LAST_POS) begin
        pos_nxt = pos_r + POS_W'(1);
        bad_nxt = bad_new;
        code_nxt = code_new;
        len_nxt = len_new;
      end else begin
        pos_nxt = '0;
        bad_nxt = 1'b0;
        cnt_nxt = '0;
        if (bad_new) begin
          emit = 1'b1;
          out_nxt.status = ST_HDR_ERR;
          out_nxt.last = 1'b1;
          code_nxt = '0;
          len_nxt = '0;
        end else if (len_new == '0) begin
          emit = 1'b1;
          out_nxt.status = ST_EMPTY;
          out_nxt.frame_code = code_new;
          out_nxt.last = 1'b1;
          code_nxt = '0;
          len_nxt = '0;
        end else begin
          pay_nxt = 1'b1;
          code_nxt = code_new;
          len_nxt = len_new;
        end
      end
    end
    out_vld_nxt = out_vld_r;
    if (core_ready) begin
      out_vld_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      pay_r <= 1'b0;
      bad_r <= 1'b0;
      code_r <= '0;
      len_r <= '0;
      cnt_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      pay_r <= pay_nxt;
      bad_r <= bad_nxt;
      code_r <= code_nxt;
      len_r <= len_nxt;
      cnt_r <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  assign res_vld = out_vld_r;
  assign res = out_r;

endmodule
`default_nettype wire

// ===== sv/ascii_length_prefixed_deframer_top.sv =====
// Top level of the ASCII length-prefixed deframer.
//
// The input stream carries one received byte per request on in_tdata. A frame
// starts with one ASCII code digit and then LENGTH_DIGITS ASCII length digits,
// most significant first, followed by that many payload bytes.
// Each payload byte leaves on the output stream with its frame code and length;
// out_tlast marks the final byte of the frame. A header with a non-digit byte
// gives one error request, and a zero-length frame gives one empty request.
// Header bytes before the last one produce nothing.
// A byte is accepted every cycle while out_tready stays high. It enters the input
// register when accepted, and its result then enters the result register,
// which drives out_tvalid.
// When the receiver holds out_tready low, the result register keeps its
// request and the input register holds one more byte, after which in_tready
// falls until the result is taken.
// Reset empties both registers and clears the decoder, which then expects a
// code digit.
`timescale 1ns / 1ps
`default_nettype none
module ascii_length_prefixed_deframer_top #(
  parameter int LENGTH_DIGITS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] payload_byte, [11:8] frame_code,
                                       // [25:12] frame_length, [31:26] zero
  output logic [1:0]       out_tuser,  // [1:0] status
  output logic             out_tlast
);
  import alpdf_pkg::*;

  alpdf_req_t req;
  alpdf_res_t res;
  logic       core_ready;

  alpdf_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .core_ready (core_ready),
    .req        (req)
  );

  alpdf_core #(
    .LENGTH_DIGITS (LENGTH_DIGITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .core_ready (core_ready),
    .res_vld    (out_tvalid),
    .res_rdy    (out_tready),
    .res        (res)
  );

  assign out_tdata = {6'd0, res.frame_length, res.frame_code, res.payload_byte};
  assign out_tuser = res.status;
  assign out_tlast = res.last;

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_HDR_ERR) |-> out_tlast && (out_tdata == 32'd0))
    else $error("header error request is not a clean last request");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY) |-> out_tlast && (out_tdata[25:12] == 14'd0)
      && (out_tdata[7:0] == 8'd0))
    else $error("empty frame request has payload or length");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != 2'd3) && (out_tdata[11:8] <= 4'd9))
    else $error("invalid status or frame code");

  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_PAYLOAD) |-> (out_tdata[25:12] != 14'd0))
    else $error("payload request in a zero-length frame");

endmodule
`default_nettype wire
